@@ hw/rtl/forth_style_data_stack_unit_assert.svh @@
// assertion macros for the data stack unit
// used by the rtl files that carry concurrent checks, no other dependencies
`ifndef FORTH_STYLE_DATA_STACK_UNIT_ASSERT_SVH
`define FORTH_STYLE_DATA_STACK_UNIT_ASSERT_SVH

// condition holds at every clock edge out of reset
`define FSDU_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("data stack invariant violated");

// consequent holds in the same cycle as the antecedent
`define FSDU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("data stack implication violated");

`endif

@@ hw/rtl/fsdu_pkg.sv @@
// shared constants, types and the microcode table of the data stack unit
// no dependencies; imported by every module of the block except fsdu_ram
`default_nettype none

package fsdu_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int WORD_W      = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int KIND_W      = 3;
  localparam int STATUS_W    = 2;
  localparam int UPC_W       = 5;

  typedef enum logic [KIND_W-1:0] {
    K_PUSH, K_DROP, K_SWAP, K_OVER, K_ROT, K_MAX, K_MIN
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK, ST_UNDER, ST_OVER
  } status_t;

  typedef enum logic [UPC_W-1:0] {
    U_IDLE,
    U_PUSH,
    U_DROP,
    U_SWAP0, U_SWAP1, U_SWAP2, U_SWAP3,
    U_OVER0, U_OVER1,
    U_ROT0, U_ROT1, U_ROT2, U_ROT3, U_ROT4, U_ROT5,
    U_RED0, U_RED1, U_RED2, U_RED3, U_REDW,
    U_TOP0, U_TOP1
  } ucode_addr_t;

  typedef enum logic [2:0] {
    A_SP, A_SPM1, A_SPM2, A_SPM3, A_IDXM1, A_ZERO
  } addr_sel_t;

  typedef enum logic [2:0] {
    WD_VAL, WD_RDATA, WD_A, WD_B, WD_BEST
  } wdata_sel_t;

  typedef enum logic [1:0] {
    BEST_HOLD, BEST_LOAD, BEST_CMP
  } best_op_t;

  typedef enum logic [1:0] {
    SP_HOLD, SP_INC, SP_DEC, SP_ONE
  } sp_op_t;

  typedef enum logic [1:0] {
    IDX_HOLD, IDX_LOAD, IDX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {
    J_NEXT, J_ALWAYS, J_IF_ZERO, J_IF_NZ
  } jump_t;

  // one control word per microcode step
  typedef struct packed {
    logic        rd_en;
    addr_sel_t   rd_sel;
    logic        wr_en;
    addr_sel_t   wr_sel;
    wdata_sel_t  wd_sel;
    logic        ld_a;
    logic        ld_b;
    best_op_t    best_op;
    sp_op_t      sp_op;
    idx_op_t     idx_op;
    jump_t       jmp;
    ucode_addr_t target;
    logic        emit;
  } ucw_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic cmd_ok;
    logic idx_zero;
    logic out_busy;
  } dp_flags_t;

  function automatic ucw_t ucode_rom(ucode_addr_t a);
    ucw_t w;
    w = '0;
    case (a)
      U_PUSH: begin
        w.wr_en = 1'b1; w.wr_sel = A_SP; w.wd_sel = WD_VAL;
        w.sp_op = SP_INC; w.jmp = J_ALWAYS; w.target = U_TOP0;
      end
      U_DROP: begin
        w.sp_op = SP_DEC; w.jmp = J_ALWAYS; w.target = U_TOP0;
      end
      U_SWAP0: begin
        w.rd_en = 1'b1; w.rd_sel = A_SPM1;
      end
      U_SWAP1: begin
        w.rd_en = 1'b1; w.rd_sel = A_SPM2; w.ld_a = 1'b1;
      end
      U_SWAP2: begin
        w.wr_en = 1'b1; w.wr_sel = A_SPM1; w.wd_sel = WD_RDATA;
      end
      U_SWAP3: begin
        w.wr_en = 1'b1; w.wr_sel = A_SPM2; w.wd_sel = WD_A;
        w.jmp = J_ALWAYS; w.target = U_TOP0;
      end
      U_OVER0: begin
        w.rd_en = 1'b1; w.rd_sel = A_SPM2;
      end
      U_OVER1: begin
        w.wr_en = 1'b1; w.wr_sel = A_SP; w.wd_sel = WD_RDATA;
        w.sp_op = SP_INC; w.jmp = J_ALWAYS; w.target = U_TOP0;
      end
      U_ROT0: begin
        w.rd_en = 1'b1; w.rd_sel = A_SPM1;
      end
      U_ROT1: begin
        w.rd_en = 1'b1; w.rd_sel = A_SPM2; w.ld_a = 1'b1;
      end
      U_ROT2: begin
        w.rd_en = 1'b1; w.rd_sel = A_SPM3; w.ld_b = 1'b1;
      end
      U_ROT3: begin
        w.wr_en = 1'b1; w.wr_sel = A_SPM1; w.wd_sel = WD_RDATA;
      end
      U_ROT4: begin
        w.wr_en = 1'b1; w.wr_sel = A_SPM2; w.wd_sel = WD_A;
      end
      U_ROT5: begin
        w.wr_en = 1'b1; w.wr_sel = A_SPM3; w.wd_sel = WD_B;
        w.jmp = J_ALWAYS; w.target = U_TOP0;
      end
      U_RED0: begin
        w.rd_en = 1'b1; w.rd_sel = A_SPM1; w.idx_op = IDX_LOAD;
      end
      U_RED1: begin
        w.best_op = BEST_LOAD; w.jmp = J_IF_ZERO; w.target = U_REDW;
      end
      U_RED2: begin
        w.rd_en = 1'b1; w.rd_sel = A_IDXM1; w.idx_op = IDX_DEC;
      end
      U_RED3: begin
        w.best_op = BEST_CMP; w.jmp = J_IF_NZ; w.target = U_RED2;
      end
      U_REDW: begin
        w.wr_en = 1'b1; w.wr_sel = A_ZERO; w.wd_sel = WD_BEST;
        w.sp_op = SP_ONE;
      end
      U_TOP0: begin
        w.rd_en = 1'b1; w.rd_sel = A_SPM1;
      end
      U_TOP1: begin
        w.emit = 1'b1; w.jmp = J_ALWAYS; w.target = U_IDLE;
      end
      default: begin
        w = '0;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fsdu_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module fsdu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hw/rtl/fsdu_sequencer.sv @@
// microcode sequencer: step counter, command dispatch and conditional jumps
// depends on fsdu_pkg for the step encoding and the control word table
`default_nettype none

module fsdu_sequencer import fsdu_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire dp_flags_t         flags,
  output logic                   in_stall,
  output ucw_t                   ctl
);

  ucode_addr_t upc_r;
  ucode_addr_t upc_nxt;
  ucode_addr_t upc_inc;
  ucode_addr_t entry;

  assign ctl      = ucode_rom(upc_r);
  assign in_stall = (upc_r != U_IDLE);
  assign upc_inc  = ucode_addr_t'(UPC_W'(upc_r) + UPC_W'(1));

  // entry step of the routine for the incoming command
  always_comb begin
    entry = U_TOP0;
    if (flags.cmd_ok) begin
      case (kind_t'(in_kind))
        K_PUSH:  entry = U_PUSH;
        K_DROP:  entry = U_DROP;
        K_SWAP:  entry = U_SWAP0;
        K_OVER:  entry = U_OVER0;
        K_ROT:   entry = U_ROT0;
        K_MAX:   entry = U_RED0;
        K_MIN:   entry = U_RED0;
        default: entry = U_TOP0;
      endcase
    end
  end

  always_comb begin
    upc_nxt = upc_r;
    if (upc_r == U_IDLE) begin
      if (in_valid) begin
        upc_nxt = entry;
      end
    end else if (!(ctl.emit && flags.out_busy)) begin
      case (ctl.jmp)
        J_NEXT:    upc_nxt = upc_inc;
        J_ALWAYS:  upc_nxt = ctl.target;
        J_IF_ZERO: upc_nxt = flags.idx_zero ? ctl.target : upc_inc;
        J_IF_NZ:   upc_nxt = flags.idx_zero ? upc_inc : ctl.target;
        default:   upc_nxt = U_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/fsdu_datapath.sv @@
// stack datapath: stack pointer, scratch registers, stack ram and result register
// depends on fsdu_pkg, fsdu_ram and the assertion macro header
`default_nettype none
`include "forth_style_data_stack_unit_assert.svh"

module fsdu_datapath import fsdu_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic [KIND_W-1:0]   in_kind,
  input  wire logic [WORD_W-1:0]   in_push_value,
  input  wire ucw_t                ctl,
  input  wire logic                out_stall,
  output dp_flags_t                flags,
  output logic                     out_valid,
  output logic [WORD_W-1:0]        out_top_value,
  output logic [SP_W-1:0]          out_depth_now,
  output logic [STATUS_W-1:0]      out_status
);

  logic [SP_W-1:0]   sp_r, sp_nxt;
  logic [ADDR_W-1:0] idx_r;
  logic [WORD_W-1:0] a_r, b_r, best_r, val_r;
  kind_t             kind_r;
  status_t           st_r, st_now;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_top_r;
  logic [SP_W-1:0]   out_depth_r;
  status_t           out_status_r;

  logic [ADDR_W-1:0] raddr, waddr;
  logic [WORD_W-1:0] wdata, rdata;
  logic              take;
  logic              out_busy;
  logic              fire;
  logic              wr_at_sp;

  function automatic logic [ADDR_W-1:0] addr_of(addr_sel_t sel, logic [SP_W-1:0] sp,
                                                logic [ADDR_W-1:0] idx);
    logic [ADDR_W-1:0] a;
    case (sel)
      A_SP:    a = sp[ADDR_W-1:0];
      A_SPM1:  a = ADDR_W'(sp - SP_W'(1));
      A_SPM2:  a = ADDR_W'(sp - SP_W'(2));
      A_SPM3:  a = ADDR_W'(sp - SP_W'(3));
      A_IDXM1: a = idx - ADDR_W'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

  // underflow is checked before overflow
  function automatic status_t check_cmd(logic [KIND_W-1:0] k, logic [SP_W-1:0] sp);
    logic [1:0] need;
    logic       grows;
    need  = 2'd0;
    grows = 1'b0;
    case (kind_t'(k))
      K_PUSH:  grows = 1'b1;
      K_DROP:  need = 2'd1;
      K_SWAP:  need = 2'd2;
      K_OVER:  begin need = 2'd2; grows = 1'b1; end
      K_ROT:   need = 2'd3;
      K_MAX:   need = 2'd1;
      K_MIN:   need = 2'd1;
      default: need = 2'd0;
    endcase
    if (sp < SP_W'(need)) begin
      return ST_UNDER;
    end else if (grows && (sp >= SP_W'(STACK_DEPTH))) begin
      return ST_OVER;
    end
    return ST_OK;
  endfunction

  assign st_now   = check_cmd(in_kind, sp_r);
  assign raddr    = addr_of(ctl.rd_sel, sp_r, idx_r);
  assign waddr    = addr_of(ctl.wr_sel, sp_r, idx_r);
  assign out_busy = out_valid_r && out_stall;
  assign fire     = ctl.emit && !out_busy;
  assign wr_at_sp = ctl.wr_en && (ctl.wr_sel == A_SP);

  assign flags.cmd_ok   = (st_now == ST_OK);
  assign flags.idx_zero = (idx_r == '0);
  assign flags.out_busy = out_busy;

  always_comb begin
    case (ctl.wd_sel)
      WD_VAL:   wdata = val_r;
      WD_RDATA: wdata = rdata;
      WD_A:     wdata = a_r;
      WD_B:     wdata = b_r;
      WD_BEST:  wdata = best_r;
      default:  wdata = '0;
    endcase
  end

  // signed compare against the running best, direction from the command
  assign take = (kind_r == K_MAX) ? ($signed(rdata) > $signed(best_r))
                                  : ($signed(rdata) < $signed(best_r));

  always_comb begin
    case (ctl.sp_op)
      SP_INC:  sp_nxt = sp_r + SP_W'(1);
      SP_DEC:  sp_nxt = sp_r - SP_W'(1);
      SP_ONE:  sp_nxt = SP_W'(1);
      default: sp_nxt = sp_r;
    endcase
  end

  fsdu_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ctl.wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ctl.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sp_r <= sp_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= kind_t'(in_kind);
      val_r  <= in_push_value;
      st_r   <= st_now;
    end
    if (ctl.ld_a) begin
      a_r <= rdata;
    end
    if (ctl.ld_b) begin
      b_r <= rdata;
    end
    case (ctl.idx_op)
      IDX_LOAD: idx_r <= ADDR_W'(sp_r - SP_W'(1));
      IDX_DEC:  idx_r <= idx_r - ADDR_W'(1);
      default:  idx_r <= idx_r;
    endcase
    case (ctl.best_op)
      BEST_LOAD: best_r <= rdata;
      BEST_CMP:  if (take) best_r <= rdata;
      default:   best_r <= best_r;
    endcase
    if (fire) begin
      out_top_r    <= (sp_r == '0) ? '0 : rdata;
      out_depth_r  <= sp_r;
      out_status_r <= st_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_top_value = out_top_r;
  assign out_depth_now = out_depth_r;
  assign out_status    = out_status_r;

  `FSDU_ASSERT_ALWAYS(a_sp_range, clk, rst_n, sp_r <= SP_W'(STACK_DEPTH))
  `FSDU_ASSERT_IMP(a_no_push_full, clk, rst_n, wr_at_sp, sp_r < SP_W'(STACK_DEPTH))
  `FSDU_ASSERT_IMP(a_idx_dec_nz, clk, rst_n, ctl.idx_op == IDX_DEC, idx_r != '0)
  `FSDU_ASSERT_IMP(a_sp_change_ok, clk, rst_n, ctl.sp_op != SP_HOLD, st_r == ST_OK)

endmodule

`default_nettype wire

@@ hw/rtl/forth_style_data_stack_unit.sv @@
// bounded data stack, one command per transaction, one result transaction each
// steps per command (at most one ram access each): push/drop 3, over 4, swap 6, rot 8, error 2,
// max/min 2*n+3 at depth n; the result step waits while the previous result is stalled
// a new command is taken only in the cycle after the last step, the result register holds meanwhile
// synchronous active-low reset empties the stack and drops result valid; ram and result values stay
// depends on fsdu_pkg, fsdu_sequencer and fsdu_datapath
`default_nettype none

module forth_style_data_stack_unit import fsdu_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [KIND_W-1:0]   in_kind,
  input  wire logic [WORD_W-1:0]   in_push_value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [WORD_W-1:0]        out_top_value,
  output logic [SP_W-1:0]          out_depth_now,
  output logic [STATUS_W-1:0]      out_status
);

  ucw_t      ctl;
  dp_flags_t flags;
  logic      accept;

  assign accept = in_valid && !in_stall;

  fsdu_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .flags    (flags),
    .in_stall (in_stall),
    .ctl      (ctl)
  );

  fsdu_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .in_kind       (in_kind),
    .in_push_value (in_push_value),
    .ctl           (ctl),
    .out_stall     (out_stall),
    .flags         (flags),
    .out_valid     (out_valid),
    .out_top_value (out_top_value),
    .out_depth_now (out_depth_now),
    .out_status    (out_status)
  );

endmodule

`default_nettype wire

@@ dv/forth_style_data_stack_checker.sv @@
// checker for the data stack unit: keeps its own copy of the stack, predicts each result
// transaction from the accepted commands and compares in order; depends on fsdu_pkg
module forth_style_data_stack_checker import fsdu_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [WORD_W-1:0]   in_push_value,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [WORD_W-1:0]   out_top_value,
  input  logic [SP_W-1:0]     out_depth_now,
  input  logic [STATUS_W-1:0] out_status,
  output int                  fail_count,
  output int                  pending,
  output int                  cmd_count,
  output int                  underflow_count,
  output int                  overflow_count,
  output int                  full_count
);

  typedef struct packed {
    logic [WORD_W-1:0] top;
    logic [SP_W-1:0]   depth;
    status_t           status;
  } stack_result_t;

  logic [WORD_W-1:0] model_words [STACK_DEPTH];
  int unsigned       model_depth;
  stack_result_t     expected_results [$];
  stack_result_t     due_result;
  stack_result_t     new_result;

  function automatic stack_result_t apply_command(input logic [KIND_W-1:0] k,
                                                  input logic [WORD_W-1:0] v);
    int unsigned       need;
    logic              grows;
    logic              take;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] best;
    stack_result_t     r;
    need = 0;
    grows = 1'b0;
    r.status = ST_OK;
    case (k)
      K_PUSH: grows = 1'b1;
      K_DROP, K_MAX, K_MIN: need = 1;
      K_SWAP: need = 2;
      K_OVER: begin
        need = 2;
        grows = 1'b1;
      end
      K_ROT: need = 3;
      default: need = 0;
    endcase
    // underflow wins over overflow
    if (model_depth < need) begin
      r.status = ST_UNDER;
    end else if (grows && model_depth >= STACK_DEPTH) begin
      r.status = ST_OVER;
    end else begin
      case (k)
        K_PUSH: begin
          model_words[model_depth] = v;
          model_depth++;
        end
        K_DROP: model_depth--;
        K_SWAP: begin
          a = model_words[model_depth-1];
          model_words[model_depth-1] = model_words[model_depth-2];
          model_words[model_depth-2] = a;
        end
        K_OVER: begin
          model_words[model_depth] = model_words[model_depth-2];
          model_depth++;
        end
        K_ROT: begin
          a = model_words[model_depth-1];
          b = model_words[model_depth-2];
          c = model_words[model_depth-3];
          model_words[model_depth-3] = b;
          model_words[model_depth-2] = a;
          model_words[model_depth-1] = c;
        end
        K_MAX, K_MIN: begin
          best = model_words[model_depth-1];
          for (int i = model_depth - 1; i > 0; i--) begin
            if (k == K_MAX) take = $signed(model_words[i-1]) > $signed(best);
            else take = $signed(model_words[i-1]) < $signed(best);
            if (take) best = model_words[i-1];
          end
          model_words[0] = best;
          model_depth = 1;
        end
        default: ;
      endcase
    end
    r.top = (model_depth > 0) ? model_words[model_depth-1] : '0;
    r.depth = SP_W'(model_depth);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      model_depth = 0;
      expected_results.delete();
      fail_count = 0;
      cmd_count = 0;
      underflow_count = 0;
      overflow_count = 0;
      full_count = 0;
    end else begin
      if (in_valid && !in_stall) begin
        new_result = apply_command(in_kind, in_push_value);
        expected_results.push_back(new_result);
        cmd_count++;
        if (new_result.status == ST_UNDER) underflow_count++;
        if (new_result.status == ST_OVER) overflow_count++;
        if (new_result.depth == STACK_DEPTH) full_count++;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no command outstanding: top %0d depth %0d status %0d",
                 $signed(out_top_value), out_depth_now, out_status);
          fail_count++;
        end else begin
          due_result = expected_results.pop_front();
          if (out_top_value !== due_result.top) begin
            $error("top_value mismatch: expected %0d, actual %0d",
                   $signed(due_result.top), $signed(out_top_value));
            fail_count++;
          end
          if (out_depth_now !== due_result.depth) begin
            $error("depth_now mismatch: expected %0d, actual %0d",
                   due_result.depth, out_depth_now);
            fail_count++;
          end
          if (out_status !== due_result.status) begin
            $error("status mismatch: expected %0d, actual %0d", due_result.status, out_status);
            fail_count++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

@@ dv/tb_forth_style_data_stack_unit.sv @@
// top of the data stack unit testbench: clock, reset, command stimulus and result stalls
// depends on fsdu_pkg, forth_style_data_stack_unit and forth_style_data_stack_checker
module tb_forth_style_data_stack_unit;
  import fsdu_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS    = 1950;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 3000;
  // slowest command is a reduction of a full stack
  localparam int DRAIN_CYCLES    = 2 * STACK_DEPTH + 8;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [KIND_W-1:0]   in_kind = '0;
  logic [WORD_W-1:0]   in_push_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [WORD_W-1:0]   out_top_value;
  logic [SP_W-1:0]     out_depth_now;
  logic [STATUS_W-1:0] out_status;

  int fail_count;
  int pending;
  int cmd_count;
  int underflow_count;
  int overflow_count;
  int full_count;

  int   sent = 0;
  int   idle_cycles = 0;
  bit   sender_quiet = 1'b0;
  bit   receiver_quiet = 1'b0;
  bit   hold_off_req = 1'b0;
  bit   hold_off_done = 1'b0;

  always #5 clk = ~clk;

  forth_style_data_stack_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_top_value (out_top_value),
    .out_depth_now (out_depth_now),
    .out_status    (out_status)
  );

  forth_style_data_stack_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_top_value   (out_top_value),
    .out_depth_now   (out_depth_now),
    .out_status      (out_status),
    .fail_count      (fail_count),
    .pending         (pending),
    .cmd_count       (cmd_count),
    .underflow_count (underflow_count),
    .overflow_count  (overflow_count),
    .full_count      (full_count)
  );

  // mostly back to back, sometimes a short pause, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // extremes and small values show up often so that reductions see ties
  function automatic logic [WORD_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      4: return WORD_W'($signed($urandom_range(0, 16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return K_PUSH;
    if (r < 40) return K_DROP;
    if (r < 52) return K_SWAP;
    if (r < 64) return K_OVER;
    if (r < 78) return K_ROT;
    if (r < 88) return K_MAX;
    if (r < 99) return K_MIN;
    return KIND_UNUSED;
  endfunction

  task automatic issue(input logic [KIND_W-1:0] k, input logic [WORD_W-1:0] v);
    int gap;
    gap = sender_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_push_value <= v;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // result side stalls; the long hold-off is requested by the stimulus
  initial begin : receiver
    int hold;
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        hold_off_done = 1'b1;
      end else if (!receiver_quiet && $urandom_range(0, 99) < 35) begin
        hold = pick_gap();
        if (hold == 0) hold = 1;
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int  r;
    int  n;
    bit  first_episode;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // everything on an empty stack underflows, the unused code just reports
    issue(K_DROP, pick_word());
    issue(K_SWAP, pick_word());
    issue(K_OVER, pick_word());
    issue(K_ROT, pick_word());
    issue(K_MAX, pick_word());
    issue(K_MIN, pick_word());
    issue(KIND_UNUSED, pick_word());
    issue(K_PUSH, 32'h7fff_ffff);
    issue(K_PUSH, 32'h8000_0000);
    issue(K_SWAP, '0);
    issue(K_OVER, '1);
    issue(K_ROT, '0);
    issue(KIND_UNUSED, '1);
    issue(K_MAX, '0);
    issue(K_PUSH, '0);
    issue(K_PUSH, '1);
    issue(K_PUSH, 32'h8000_0000);
    issue(K_MIN, '0);
    issue(K_DROP, '0);
    issue(K_DROP, '1);

    first_episode = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      sender_quiet = ($urandom_range(0, 4) == 0);
      receiver_quiet = ($urandom_range(0, 4) == 0);
      if (!hold_off_done && !hold_off_req && sent > 700) begin
        hold_off_req = 1'b1;
        sender_quiet = 1'b1;
      end
      r = first_episode ? 0 : $urandom_range(0, 99);
      first_episode = 1'b0;
      if (r < 15) begin
        // fill to the top, then try to grow past it
        n = $urandom_range(14, 20);
        repeat (n) issue(K_PUSH, pick_word());
        repeat ($urandom_range(1, 3))
          issue($urandom_range(0, 1) ? K_PUSH : K_OVER, pick_word());
      end else if (r < 25) begin
        // drop a run of words, which may empty it, then issue random commands
        n = $urandom_range(10, 18);
        repeat (n) issue(K_DROP, pick_word());
        repeat ($urandom_range(1, 3)) issue(pick_kind(), pick_word());
      end else if (r < 35) begin
        n = $urandom_range(0, 8);
        repeat (n) issue(K_PUSH, pick_word());
        issue($urandom_range(0, 1) ? K_MAX : K_MIN, pick_word());
      end else begin
        n = $urandom_range(10, 40);
        repeat (n) issue(pick_kind(), pick_word());
      end
    end
    in_valid <= 1'b0;
    receiver_quiet = 1'b0;

    // let the checker book the last accepted transaction before polling
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d commands: %0d underflow, %0d overflow, full stack reached %0d times",
             cmd_count, underflow_count, overflow_count, full_count);
    $display("results were held off %0d cycles once while commands kept coming",
             HOLD_OFF_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
